// ----- rtl/pwmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// pwmsr_pkg
// Shared constants and types for the three-channel PWM slew ramp unit.
// ----------------------------------------------------------------------------
package pwmsr_pkg;

  // Number of duty channels and width of a duty level.
  localparam int CHANNELS       = 3;
  localparam int LEVEL_BITS     = 16;

  // Fixed widths of the external fields.
  localparam int OUT_FIELDS     = 3;
  localparam int OUT_LEVEL_BITS = 16;
  localparam int PERIOD_BITS    = 8;

  // Register map: register i sits at byte address 4*i.
  localparam int NUM_REGS       = 5;
  localparam int PADDR_BITS     = 5;
  localparam int PDATA_BITS     = 32;
  localparam int REG_IDX_BITS   = PADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_RAMP_PERIOD = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_LEVEL   = REG_IDX_BITS'(1);
  localparam int                      REG_TARGET_BASE = 2;

  typedef logic [LEVEL_BITS-1:0]  level_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // Per-channel state as reported in one result.
  typedef struct packed {
    level_t level;
    logic   enable;
    logic   changed;
  } chan_res_t;

endpackage

// ----- rtl/pwmsr_regs.sv -----
// ----------------------------------------------------------------------------
// pwmsr_regs
// APB register file holding the ramp period, minimum level and targets.
// ----------------------------------------------------------------------------
module pwmsr_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmsr_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [pwmsr_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [pwmsr_pkg::PDATA_BITS-1:0]   prdata,
  output logic                               pready,
  output pwmsr_pkg::period_t                 ramp_period,
  output pwmsr_pkg::level_t                  min_level,
  output pwmsr_pkg::level_t                  target_levels [pwmsr_pkg::CHANNELS]
);
  import pwmsr_pkg::*;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx    = paddr[PADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_period <= '0;
      min_level   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        target_levels[c] <= '0;
      end
    end else if (wr_en) begin
      if (idx == REG_RAMP_PERIOD) begin
        ramp_period <= pwdata[PERIOD_BITS-1:0];
      end
      if (idx == REG_MIN_LEVEL) begin
        min_level <= pwdata[LEVEL_BITS-1:0];
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if ((REG_TARGET_BASE + c < NUM_REGS) && (int'(idx) == REG_TARGET_BASE + c)) begin
          target_levels[c] <= pwdata[LEVEL_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_RAMP_PERIOD: prdata = PDATA_BITS'(ramp_period);
      REG_MIN_LEVEL:   prdata = PDATA_BITS'(min_level);
      default: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if ((REG_TARGET_BASE + c < NUM_REGS) && (int'(idx) == REG_TARGET_BASE + c)) begin
            prdata = PDATA_BITS'(target_levels[c]);
          end
        end
      end
    endcase
  end

endmodule

// ----- rtl/pwmsr_chan.sv -----
// ----------------------------------------------------------------------------
// pwmsr_chan
// One duty channel: level and enable state, one-step slew toward the target.
// ----------------------------------------------------------------------------
module pwmsr_chan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  pwmsr_pkg::level_t    target_level,
  input  pwmsr_pkg::level_t    min_level,
  output pwmsr_pkg::chan_res_t res
);
  import pwmsr_pkg::*;

  level_t                level;
  logic                  enable;
  level_t                level_next;
  logic                  enable_next;
  logic                  moved;
  logic [LEVEL_BITS:0]   min_plus_one;

  // The on threshold is one bit wider so a minimum at full scale never wraps.
  assign min_plus_one = {1'b0, min_level} + (LEVEL_BITS + 1)'(1);
  assign moved        = step && (level != target_level);

  always_comb begin
    level_next  = level;
    enable_next = enable;
    if (moved) begin
      if (level < target_level) begin
        level_next = level + LEVEL_BITS'(1);
      end else begin
        level_next = level - LEVEL_BITS'(1);
      end
      if (level_next == min_level) begin
        enable_next = 1'b0;
      end else if (({1'b0, level_next} == min_plus_one) && (target_level > min_level)) begin
        enable_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      enable <= 1'b0;
    end else begin
      level  <= level_next;
      enable <= enable_next;
    end
  end

  assign res.level   = level_next;
  assign res.enable  = enable_next;
  assign res.changed = moved;

endmodule

// ----- rtl/three_channel_pwm_slew_ramp_unit.sv -----
// ----------------------------------------------------------------------------
// three_channel_pwm_slew_ramp_unit
// Slew-rate limiter for three PWM duty levels, driven by millisecond ticks.
// ----------------------------------------------------------------------------
// Each accepted transaction on the input channel carries one tick bit. A tick
// of one counts the step divider down; when the divider is already zero it
// reloads from ramp_period and every channel moves its duty level one count
// toward its target, so levels step once every ramp_period+1 ticks. A channel
// that steps onto min_level switches its output off, and one that steps onto
// min_level+1 while its target is above min_level switches it back on. Every
// input transaction produces exactly one output transaction carrying the new
// levels, enables and per-channel changed flags. The whole update is a single
// compare, increment or decrement and reload, done in the cycle the input is
// accepted and captured in an output register, so the unit takes one input
// transaction per clock while results are taken, being stalled only while the
// output register holds an untaken result. Configuration registers are to be
// written over the APB port only while the unit is idle; this is not enforced.
module three_channel_pwm_slew_ramp_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               tick,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pwmsr_pkg::OUT_LEVEL_BITS-1:0] level_a,
  output logic [pwmsr_pkg::OUT_LEVEL_BITS-1:0] level_b,
  output logic [pwmsr_pkg::OUT_LEVEL_BITS-1:0] level_c,
  output logic                               enable_a,
  output logic                               enable_b,
  output logic                               enable_c,
  output logic                               changed_a,
  output logic                               changed_b,
  output logic                               changed_c,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmsr_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [pwmsr_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [pwmsr_pkg::PDATA_BITS-1:0]   prdata,
  output logic                               pready
);
  import pwmsr_pkg::*;

  period_t   ramp_period;
  level_t    min_level;
  level_t    target_levels [CHANNELS];

  period_t   step_divider;
  logic      accept;
  logic      step;

  chan_res_t chan_res [CHANNELS];
  chan_res_t field_res [OUT_FIELDS];
  chan_res_t result [OUT_FIELDS];

  pwmsr_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .ramp_period   (ramp_period),
    .min_level     (min_level),
    .target_levels (target_levels)
  );

  // A new transaction is taken whenever the output register is empty or is
  // being emptied in the same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // The levels step on a tick that finds the divider at zero.
  assign step = accept && tick && (step_divider == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_divider <= '0;
    end else if (accept && tick) begin
      if (step_divider == '0) begin
        step_divider <= ramp_period;
      end else begin
        step_divider <= step_divider - PERIOD_BITS'(1);
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    pwmsr_chan u_chan (
      .clk          (clk),
      .rst          (rst),
      .step         (step),
      .target_level (target_levels[c]),
      .min_level    (min_level),
      .res          (chan_res[c])
    );
  end

  // Result slots with no channel behind them report zero.
  for (genvar f = 0; f < OUT_FIELDS; f++) begin : g_field
    if (f < CHANNELS) begin : g_live
      assign field_res[f] = chan_res[f];
    end else begin : g_absent
      assign field_res[f] = '0;
    end
  end

  // Output register. The payload is loaded only with a transaction, so it
  // holds steady while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int f = 0; f < OUT_FIELDS; f++) begin
        result[f] <= field_res[f];
      end
    end
  end

  assign level_a   = OUT_LEVEL_BITS'(result[0].level);
  assign level_b   = OUT_LEVEL_BITS'(result[1].level);
  assign level_c   = OUT_LEVEL_BITS'(result[2].level);
  assign enable_a  = result[0].enable;
  assign enable_b  = result[1].enable;
  assign enable_c  = result[2].enable;
  assign changed_a = result[0].changed;
  assign changed_b = result[1].changed;
  assign changed_c = result[2].changed;

  // A step reloads the divider from the programmed period.
  a_reload: assert property (@(posedge clk) disable iff (rst)
    step |=> (step_divider == $past(ramp_period)))
    else $error("step divider did not reload on a level step");

  // The divider only moves on an accepted transaction.
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(step_divider))
    else $error("step divider moved without an accepted transaction");

  // Every accepted transaction leaves a result waiting in the output register.
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // No channel reports a change unless the divider allowed a step.
  a_changed: assert property (@(posedge clk) disable iff (rst)
    (accept && !step) |=> (!changed_a && !changed_b && !changed_c))
    else $error("channel reported a change without a level step");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the three-channel PWM slew ramp unit.
// ----------------------------------------------------------------------------
// Tick transactions go into the input channel. Each accepted tick also runs
// a duty ramp predictor inside this module, and the predictor's result goes
// into a queue. Every result that the unit hands out is checked field by
// field against the oldest queued result. The ramp settings are written and
// read back over APB while nothing is in flight. Both channels insert random
// idle cycles, and some stretches run with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmsr_pkg::*;

  // One result holds the reported state of every channel, channel 0 in slot 0.
  typedef chan_res_t [CHANNELS-1:0] ramp_result_t;

  localparam logic        DO_WRITE       = 1'b1;
  localparam logic        DO_READ        = 1'b0;
  localparam int unsigned CYCLE_LIMIT    = 200_000;
  localparam int          MAX_REPORTED   = 10;
  localparam int          ADDR_SLOTS     = 1 << REG_IDX_BITS;
  localparam int unsigned SLOW_RAMP_TICKS = 256;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  tick;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUT_LEVEL_BITS-1:0] level_a;
  logic [OUT_LEVEL_BITS-1:0] level_b;
  logic [OUT_LEVEL_BITS-1:0] level_c;
  logic                  enable_a;
  logic                  enable_b;
  logic                  enable_c;
  logic                  changed_a;
  logic                  changed_b;
  logic                  changed_c;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  // Shadow copy of the ramp settings, updated whenever APB writes them.
  period_t ramp_cfg;
  level_t  min_cfg;
  level_t  target_cfg [CHANNELS];

  // Predicted state of the unit: step divider, duty levels and output enables.
  period_t step_count;
  level_t  chan_level [CHANNELS];
  logic    chan_on    [CHANNELS];

  // Results that the predictor produced and the unit has not yet delivered.
  ramp_result_t expected_duty_q [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        send_gaps_on;
  logic        recv_stalls_on;
  string       chan_tags;

  three_channel_pwm_slew_ramp_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level_a   (level_a),
    .level_b   (level_b),
    .level_c   (level_c),
    .enable_a  (enable_a),
    .enable_b  (enable_b),
    .enable_c  (enable_c),
    .changed_a (changed_a),
    .changed_b (changed_b),
    .changed_c (changed_c),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the unit stops delivering results.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Only the first few mismatches are printed; all of them are counted.
  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
  endfunction

  // Duty ramp predictor. It advances the predicted state by one input
  // transaction and returns the result that the unit must report for it.
  // The divider only counts ticks; when it is already zero it reloads from
  // the ramp period and every channel steps one count toward its target.
  function automatic ramp_result_t advance_ramp(input logic tick_in);
    ramp_result_t res;
    level_t       nxt;
    logic         moved;
    logic         reload;
    reload = tick_in && (step_count == '0);
    for (int c = 0; c < CHANNELS; c++) begin
      moved = 1'b0;
      if (reload) begin
        nxt = chan_level[c];
        if (nxt < target_cfg[c]) begin
          nxt = nxt + 1'b1;
          moved = 1'b1;
        end else if (nxt > target_cfg[c]) begin
          nxt = nxt - 1'b1;
          moved = 1'b1;
        end
        chan_level[c] = nxt;
        if (moved) begin
          // A step onto the minimum turns the output off. The minimum plus one
          // is formed wider than a level, so a minimum at full scale never
          // turns an output back on.
          if (nxt == min_cfg) begin
            chan_on[c] = 1'b0;
          end
          if (int'(nxt) == int'(min_cfg) + 1 && target_cfg[c] > min_cfg) begin
            chan_on[c] = 1'b1;
          end
        end
      end
      res[c].level   = chan_level[c];
      res[c].enable  = chan_on[c];
      res[c].changed = moved;
    end
    if (tick_in) begin
      step_count = reload ? ramp_cfg : step_count - 1'b1;
    end
    return res;
  endfunction

  // Both channels are watched at the rising edge. An accepted tick queues its
  // prediction first, so the check below would also hold for a unit that
  // answered in the same cycle.
  always @(posedge clk) begin : result_monitor
    ramp_result_t seen;
    ramp_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_duty_q.push_back(advance_ramp(tick));
      end
      if (out_valid && out_ready) begin
        seen[0] = '{level: level_a, enable: enable_a, changed: changed_a};
        seen[1] = '{level: level_b, enable: enable_b, changed: changed_b};
        seen[2] = '{level: level_c, enable: enable_c, changed: changed_c};
        if (expected_duty_q.size() == 0) begin
          report_mismatch("result transaction with no tick outstanding");
        end else begin
          want = expected_duty_q.pop_front();
          for (int c = 0; c < CHANNELS; c++) begin
            if (seen[c].level !== want[c].level) begin
              report_mismatch($sformatf("level_%c expected %0d, got %0d",
                chan_tags[c], want[c].level, seen[c].level));
            end
            if (seen[c].enable !== want[c].enable) begin
              report_mismatch($sformatf("enable_%c expected %0b, got %0b",
                chan_tags[c], want[c].enable, seen[c].enable));
            end
            if (seen[c].changed !== want[c].changed) begin
              report_mismatch($sformatf("changed_%c expected %0b, got %0b",
                chan_tags[c], want[c].changed, seen[c].changed));
            end
          end
        end
      end
    end
  end

  // Output side: before taking each result the receiver holds ready low for
  // a random number of cycles, unless stalls are switched off. With no stall
  // ready simply stays high for the next transaction.
  initial begin : result_receiver
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = recv_stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Sends one tick transaction. Called and returns at a falling edge. When no
  // gap is drawn, valid stays high straight into the next transaction.
  task automatic send_item(input logic tick_val);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    tick     <= tick_val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every predicted result has been delivered.
  // Each tick gives exactly one result, so nothing is left in flight then.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_duty_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, then an idle cycle so that
  // back-to-back transfers never assign the bus signals twice in one step.
  // Writes update the shadow settings; reads are compared against them.
  task automatic apb_access(input logic is_write, input int idx,
                            input logic [PDATA_BITS-1:0] wdata);
    logic [PDATA_BITS-1:0] shadow;
    logic                  mapped;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= PADDR_BITS'(idx << 2);
    pwdata  <= is_write ? wdata : '0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mapped = 1'b1;
    shadow = '0;
    if (idx == int'(REG_RAMP_PERIOD)) begin
      if (is_write) ramp_cfg = wdata[PERIOD_BITS-1:0];
      shadow = PDATA_BITS'(ramp_cfg);
    end else if (idx == int'(REG_MIN_LEVEL)) begin
      if (is_write) min_cfg = wdata[LEVEL_BITS-1:0];
      shadow = PDATA_BITS'(min_cfg);
    end else if (idx >= REG_TARGET_BASE && idx < REG_TARGET_BASE + CHANNELS) begin
      if (is_write) target_cfg[idx - REG_TARGET_BASE] = wdata[LEVEL_BITS-1:0];
      shadow = PDATA_BITS'(target_cfg[idx - REG_TARGET_BASE]);
    end else begin
      // Writes to unmapped addresses must leave every setting alone.
      mapped = 1'b0;
    end
    if (!is_write && mapped && prdata !== shadow) begin
      report_mismatch($sformatf("register %0d read expected 0x%0h, got 0x%0h",
        idx, shadow, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(DO_READ, i, '0);
    end
  endtask

  // Right after reset all settings read zero, and neither an empty
  // transaction nor a tick with every target at zero moves anything.
  task automatic test_reset_values();
    check_registers();
    send_item(1'b0);
    send_item(1'b1);
  endtask

  // All three channels climb through the minimum and back down. The
  // minimum is one, so each output switches off on level one and on at two.
  // Channel b gets a write with junk above its sixteen bits, which must be
  // dropped and leave a full-scale target. On the way down the output stays on
  // at level two because the target is no longer above the minimum.
  task automatic test_ramp_through_min();
    wait_idle();
    apb_access(DO_WRITE, REG_RAMP_PERIOD, 32'd0);
    apb_access(DO_WRITE, REG_MIN_LEVEL, 32'd1);
    apb_access(DO_WRITE, REG_TARGET_BASE + 0, 32'd3);
    apb_access(DO_WRITE, REG_TARGET_BASE + 1, 32'hABCD_FFFF);
    apb_access(DO_WRITE, REG_TARGET_BASE + 2, 32'd2);
    check_registers();
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b1);
    wait_idle();
    apb_access(DO_WRITE, REG_TARGET_BASE + 0, 32'd0);
    apb_access(DO_WRITE, REG_TARGET_BASE + 1, 32'd1);
    apb_access(DO_WRITE, REG_TARGET_BASE + 2, 32'd0);
    repeat (4) send_item(1'b1);
  endtask

  // With the minimum at full scale the minimum plus one must not wrap to
  // zero, so no output is switched on. The ramp period of one makes every
  // other tick a step.
  task automatic test_min_at_top();
    wait_idle();
    apb_access(DO_WRITE, REG_MIN_LEVEL, 32'hFFFF_FFFF);
    apb_access(DO_WRITE, REG_RAMP_PERIOD, 32'd1);
    apb_access(DO_WRITE, REG_TARGET_BASE + 0, 32'h0000_0002);
    apb_access(DO_WRITE, REG_TARGET_BASE + 2, 32'h0001_0005);
    check_registers();
    repeat (6) send_item(1'b1);
  endtask

  // Writes to the addresses past the register map must change nothing.
  task automatic test_unmapped_writes();
    wait_idle();
    for (int k = NUM_REGS; k < ADDR_SLOTS; k++) begin
      apb_access(DO_WRITE, k, $urandom);
    end
    check_registers();
    send_item(1'b1);
    send_item(1'b1);
  endtask

  // Longest ramp period: the divider reloads at 255 and has to count all the
  // way down before the next step. Once it is back at zero the period drops
  // to zero and one more tick takes the step, which reloads zero, so later
  // phases start clean. The second half runs without idling on either side.
  task automatic test_slow_divider();
    int unsigned ones;
    logic        tick_val;
    wait_idle();
    apb_access(DO_WRITE, REG_RAMP_PERIOD, 32'hFFFF_FFFF);
    for (int c = 0; c < CHANNELS; c++) begin
      apb_access(DO_WRITE, REG_TARGET_BASE + c,
                 32'(chan_level[c]) + $urandom_range(0, 4) - 2);
    end
    check_registers();
    ones = 0;
    while (ones < SLOW_RAMP_TICKS || step_count != '0) begin
      if (ones >= SLOW_RAMP_TICKS / 2) begin
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
      end
      tick_val = ($urandom_range(0, 9) != 0);
      send_item(tick_val);
      if (tick_val) ones++;
    end
    wait_idle();
    apb_access(DO_WRITE, REG_RAMP_PERIOD, 32'd0);
    send_item(1'b1);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // Random phases. Most settings keep the levels, targets and minimum close
  // together so that channels keep crossing the minimum, hitting their
  // targets and reversing. Now and then a full random word is written, which
  // also exercises the dropped upper bits of the data bus.
  task automatic test_random_phases();
    int unsigned          n;
    int unsigned          kind;
    logic [PDATA_BITS-1:0] val;
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      apb_access(DO_WRITE, REG_RAMP_PERIOD, $urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        val = $urandom;
      end else if (kind == 1) begin
        val = '0;
      end else if (kind == 2) begin
        val = 32'hFFFF_FFFF;
      end else begin
        val = 32'(chan_level[$urandom_range(0, CHANNELS - 1)]) + $urandom_range(0, 4) - 2;
      end
      apb_access(DO_WRITE, REG_MIN_LEVEL, val);
      for (int c = 0; c < CHANNELS; c++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          val = $urandom;
        end else if (kind < 5) begin
          val = 32'(min_cfg) + $urandom_range(0, 6) - 3;
        end else begin
          val = 32'(chan_level[c]) + $urandom_range(0, 16) - 8;
        end
        apb_access(DO_WRITE, REG_TARGET_BASE + c, val);
      end
      check_registers();
      n = $urandom_range(8, 16);
      repeat (n) send_item($urandom_range(0, 5) != 0);
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    tick           = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    chan_tags      = "abc";
    ramp_cfg       = '0;
    min_cfg        = '0;
    step_count     = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      target_cfg[c] = '0;
      chan_level[c] = '0;
      chan_on[c]    = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_ramp_through_min();
    test_min_at_top();
    test_unmapped_writes();
    test_slow_divider();
    test_random_phases();

    // Let the last result drain, then keep the monitor running in case the unit
    // hands out anything nobody asked for.
    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_duty_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- three_channel_pwm_slew_ramp_unit.f -----
rtl/pwmsr_pkg.sv
rtl/pwmsr_regs.sv
rtl/pwmsr_chan.sv
rtl/three_channel_pwm_slew_ramp_unit.sv
tb/testbench.sv
